>>> src/alids_pkg.sv
// Shared types and codes for the array list unit: word type, action codes
// and result status codes. No dependencies.
`default_nettype none

package alids_pkg;

	localparam int DATA_W = 32;
	localparam int ACT_W  = 3;
	localparam int STAT_W = 2;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [ACT_W-1:0]         act_t;
	typedef logic [STAT_W-1:0]        stat_t;

	localparam act_t ACT_CLEAR  = 3'd0;
	localparam act_t ACT_APPEND = 3'd1;
	localparam act_t ACT_INSERT = 3'd2;
	localparam act_t ACT_DELETE = 3'd3;
	localparam act_t ACT_SEARCH = 3'd4;
	localparam act_t ACT_READ   = 3'd5;

	localparam stat_t ST_OK    = 2'd0;
	localparam stat_t ST_FULL  = 2'd1;
	localparam stat_t ST_RANGE = 2'd2;
	localparam stat_t ST_EMPTY = 2'd3;

endpackage

`default_nettype wire

>>> src/alids_ram.sv
// Entry store of the array list: one write port, one read port, registered
// read data. Uses alids_pkg for the word type.
`default_nettype none

module alids_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [ADDR_W-1:0]   waddr,
	input  wire alids_pkg::word_t    wdata,
	input  wire logic [ADDR_W-1:0]   raddr,
	output alids_pkg::word_t         rdata
);
	import alids_pkg::*;

	word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/array_list_insert_delete_search_unit.sv
// Array list unit: positional insert/delete and linear search over a list
// of signed 32-bit words. Depends on alids_pkg and alids_ram.
//
// Usage:
//  - Present action, value and position with start high. The item is taken
//    at a rising edge where start is high and busy is low; busy stays high
//    until the item's last result has been issued.
//  - Results appear on status, found_position, element, hit and last for
//    exactly one cycle, marked by valid. The receiver cannot stall; every
//    strobed result must be captured. last marks the final result of an item.
//  - Clear, append, unknown actions and rejected commands: one result in the
//    cycle after the item is taken.
//  - Insert at position p in a list of n entries: entries p..n move up one
//    place, top first; the write and result follow (p = n+1 just appends).
//  - Delete at position p: n-p moves, result in the cycle after the last one.
//  - Read all: one entry per cycle from the read port. Search: each match
//    is held until the next one turns up; the final match (or the no-match
//    result) follows the walk.
//  - One read, one write port; the walk sets the rate, new items wait on busy.
//  - Reset empties the list (count to zero); the store itself is not cleared.
`default_nettype none

module array_list_insert_delete_search_unit #(
	parameter int CAPACITY = 64,
	localparam int POS_W   = $clog2(CAPACITY + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire alids_pkg::act_t     action,
	input  wire alids_pkg::word_t    value,
	input  wire logic [POS_W-1:0]    position,
	output logic                     valid,
	output alids_pkg::stat_t         status,
	output logic [POS_W-1:0]         found_position,
	output alids_pkg::word_t         element,
	output logic                     hit,
	output logic                     last
);
	import alids_pkg::*;

	localparam int ADDR_W = $clog2(CAPACITY);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SHUP = 3'd1; // insert: move entries up
	localparam logic [2:0] S_INSW = 3'd2; // insert: write new value
	localparam logic [2:0] S_SHDN = 3'd3; // delete: move entries down
	localparam logic [2:0] S_SCAN = 3'd4; // search or read all
	localparam logic [2:0] S_SEND = 3'd5; // search: issue the final result

	localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);
	localparam logic [POS_W-1:0] ONE_P = POS_W'(1);
	localparam logic [POS_W-1:0] TWO_P = POS_W'(2);

	logic [2:0]       state_q, state_d;
	logic             busy_q;
	logic [POS_W-1:0] count_q, count_d;
	logic [POS_W-1:0] ptr_q, ptr_d;
	logic [POS_W-1:0] pos_q;
	word_t            value_q;
	logic             read_mode_q;
	logic             matched_q, matched_d;
	logic [POS_W-1:0] pend_pos_q, pend_pos_d;

	logic             valid_q;
	stat_t            status_q;
	logic [POS_W-1:0] found_q;
	word_t            element_q;
	logic             hit_q, last_q;

	logic             res_v, res_hit, res_last;
	stat_t            res_status;
	logic [POS_W-1:0] res_pos;
	word_t            res_elem;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	word_t             mem_wdata, mem_rdata;

	logic             accept;
	logic             full, empty;
	logic [POS_W-1:0] cnt_m1, cnt_p1, in_pos_m1;
	logic [POS_W-1:0] ptr_m1, ptr_m2, ptr_p1, ptr_p2, pos_m1;
	logic             is_last, match;

	assign accept    = start & ~busy_q;
	assign full      = (count_q == CAP_P);
	assign empty     = (count_q == '0);
	assign cnt_m1    = count_q - ONE_P;
	assign cnt_p1    = count_q + ONE_P;
	assign in_pos_m1 = position - ONE_P;
	assign ptr_m1    = ptr_q - ONE_P;
	assign ptr_m2    = ptr_q - TWO_P;
	assign ptr_p1    = ptr_q + ONE_P;
	assign ptr_p2    = ptr_q + TWO_P;
	assign pos_m1    = pos_q - ONE_P;
	assign is_last   = (ptr_p1 == count_q);
	assign match     = (mem_rdata == value_q);

	alids_ram #(
		.DEPTH  (CAPACITY),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		ptr_d      = ptr_q;
		matched_d  = matched_q;
		pend_pos_d = pend_pos_q;
		mem_we     = 1'b0;
		mem_waddr  = count_q[ADDR_W-1:0];
		mem_wdata  = value;
		mem_raddr  = '0;
		res_v      = 1'b0;
		res_status = ST_OK;
		res_pos    = '0;
		res_elem   = '0;
		res_hit    = 1'b0;
		res_last   = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_v = 1'b1;
					unique case (action)
						ACT_CLEAR: begin
							count_d = '0;
						end
						ACT_APPEND: begin
							if (full) begin
								res_status = ST_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = cnt_p1;
							end
						end
						ACT_INSERT: begin
							priority if (full) begin
								res_status = ST_FULL;
							end else if (position == '0 || position > cnt_p1) begin
								res_status = ST_RANGE;
							end else if (position == cnt_p1) begin
								// insert at the tail: plain append
								mem_we  = 1'b1;
								count_d = cnt_p1;
							end else begin
								// read the tail entry, move it up next cycle
								res_v     = 1'b0;
								mem_raddr = cnt_m1[ADDR_W-1:0];
								ptr_d     = count_q;
								state_d   = S_SHUP;
							end
						end
						ACT_DELETE: begin
							priority if (empty) begin
								res_status = ST_EMPTY;
							end else if (position == '0 || position > count_q) begin
								res_status = ST_RANGE;
							end else if (position == count_q) begin
								// tail entry: drop it
								count_d = cnt_m1;
							end else begin
								res_v     = 1'b0;
								mem_raddr = position[ADDR_W-1:0];
								ptr_d     = in_pos_m1;
								state_d   = S_SHDN;
							end
						end
						ACT_SEARCH, ACT_READ: begin
							if (empty) begin
								res_status = ST_EMPTY;
							end else begin
								res_v     = 1'b0;
								mem_raddr = '0;
								ptr_d     = '0;
								matched_d = 1'b0;
								state_d   = S_SCAN;
							end
						end
						default: begin
							// unknown action: acknowledge only
						end
					endcase
				end
			end
			S_SHUP: begin
				// entry ptr-1 arrived; write it at ptr
				mem_we    = 1'b1;
				mem_waddr = ptr_q[ADDR_W-1:0];
				mem_wdata = mem_rdata;
				if (ptr_q == pos_q) begin
					state_d = S_INSW;
				end else begin
					mem_raddr = ptr_m2[ADDR_W-1:0];
					ptr_d     = ptr_m1;
				end
			end
			S_INSW: begin
				mem_we    = 1'b1;
				mem_waddr = pos_m1[ADDR_W-1:0];
				mem_wdata = value_q;
				count_d   = cnt_p1;
				res_v     = 1'b1;
				state_d   = S_IDLE;
			end
			S_SHDN: begin
				// entry ptr+1 arrived; write it at ptr
				mem_we    = 1'b1;
				mem_waddr = ptr_q[ADDR_W-1:0];
				mem_wdata = mem_rdata;
				if (ptr_p2 == count_q) begin
					count_d = cnt_m1;
					res_v   = 1'b1;
					state_d = S_IDLE;
				end else begin
					mem_raddr = ptr_p2[ADDR_W-1:0];
					ptr_d     = ptr_p1;
				end
			end
			S_SCAN: begin
				if (read_mode_q) begin
					res_v    = 1'b1;
					res_hit  = 1'b1;
					res_pos  = ptr_p1;
					res_elem = mem_rdata;
					res_last = is_last;
				end else if (match) begin
					// issue the held match, hold this one in its place
					res_v      = matched_q;
					res_hit    = 1'b1;
					res_pos    = pend_pos_q;
					res_last   = 1'b0;
					matched_d  = 1'b1;
					pend_pos_d = ptr_p1;
				end
				if (is_last) begin
					if (read_mode_q) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_SEND;
					end
				end else begin
					mem_raddr = ptr_p1[ADDR_W-1:0];
					ptr_d     = ptr_p1;
				end
			end
			S_SEND: begin
				// final search result: the held match, or no match at all
				res_v   = 1'b1;
				res_hit = matched_q;
				res_pos = matched_q ? pend_pos_q : '0;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			busy_q     <= 1'b0;
			count_q    <= '0;
			ptr_q      <= '0;
			matched_q  <= 1'b0;
			pend_pos_q <= '0;
			valid_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			busy_q     <= (state_d != S_IDLE);
			count_q    <= count_d;
			ptr_q      <= ptr_d;
			matched_q  <= matched_d;
			pend_pos_q <= pend_pos_d;
			valid_q    <= res_v;
		end
	end

	// hold the item's operands for the walk; result payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q     <= value;
			pos_q       <= position;
			read_mode_q <= (action == ACT_READ);
		end
		status_q  <= res_status;
		found_q   <= res_pos;
		element_q <= res_elem;
		hit_q     <= res_hit;
		last_q    <= res_last;
	end

	assign busy           = busy_q;
	assign valid          = valid_q;
	assign status         = status_q;
	assign found_position = found_q;
	assign element        = element_q;
	assign hit            = hit_q;
	assign last           = last_q;

endmodule

`default_nettype wire
